@@ rtl/task_sleep_timer_queue_core_macros.svh @@
// assertion macros for the sleep timer queue core
`ifndef TASK_SLEEP_TIMER_QUEUE_CORE_MACROS_SVH
`define TASK_SLEEP_TIMER_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define TSQ_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsq assertion failed");

// next-cycle implication, checked out of reset
`define TSQ_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsq assertion failed");

`else

`define TSQ_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define TSQ_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/tsq_pkg.sv @@
// shared types and constants for the sleep timer queue
`default_nettype none

package tsq_pkg;

    localparam int TASK_W = 8;
    localparam int TICK_W = 16;

    // tick count that marks a timer as off
    localparam logic [TICK_W-1:0] TIMEROFF16 = 16'hFFFF;

    // request kinds
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_SLEEP = 1'b1;

    // sleep status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [TASK_W-1:0] task_id;
        logic [TICK_W-1:0] ticks;
    } entry_t;

    typedef struct packed {
        logic              wake;
        logic [TICK_W-1:0] ticks;
    } eval_t;

endpackage

`default_nettype wire

@@ rtl/tsq_entry_eval.sv @@
// per-entry countdown unit shared by every step of the tick walk
`default_nettype none

module tsq_entry_eval (
    input  wire logic [tsq_pkg::TICK_W-1:0] ticks,
    output tsq_pkg::eval_t                  res
);
    import tsq_pkg::*;

    logic [TICK_W-1:0] dec;

    // decrement, off value wakes without counting
    assign dec = ticks - TICK_W'(1);

    always_comb
    begin
        if (ticks == TIMEROFF16)
        begin
            res.wake  = 1'b1;
            res.ticks = ticks;
        end
        else
        begin
            res.wake  = (dec == '0);
            res.ticks = dec;
        end
    end

endmodule

`default_nettype wire

@@ rtl/task_sleep_timer_queue_core.sv @@
// sleep request: status result on the strobe in the cycle after it is accepted.
// tick request: walks the queue one entry per cycle through one entry memory read port and
// one countdown unit; busy through the scan and finish states, each wake report is held
// until the next wake or the finish state, the final one in the first idle cycle.
// a tick on an empty queue does not leave idle and gives no result.
// the receiver cannot stall; every result is shown for exactly one cycle.
// reset empties the queue and clears the sequencer; entry storage is not cleared.
`default_nettype none

module task_sleep_timer_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        req_type,
    input  wire logic [tsq_pkg::TASK_W-1:0]  task_id,
    input  wire logic [tsq_pkg::TICK_W-1:0]  sleep_ticks,
    output logic                             result_strobe,
    output logic                             is_wake,
    output logic [tsq_pkg::TASK_W-1:0]       woken_task,
    output logic                             status,
    output logic                             last
);
    import tsq_pkg::*;

    `include "task_sleep_timer_queue_core_macros.svh"

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  keep_reg, keep_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [TASK_W-1:0] pend_task_reg, pend_task_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_wake_reg, out_wake_next;
    logic [TASK_W-1:0] out_task_reg, out_task_next;
    logic              out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    entry_t            mem [QUEUE_DEPTH];
    entry_t            rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    logic              accept;
    logic              sleep_full;
    logic [TICK_W-1:0] ticks_adj;
    logic [CNT_W-1:0]  rd_idx_inc;
    logic              last_entry;
    eval_t             ev;

    assign accept     = start && !busy;
    assign sleep_full = (count_reg == DEPTH_CNT);
    assign ticks_adj  = (sleep_ticks == TIMEROFF16) ? (TIMEROFF16 - TICK_W'(1))
                                                    : sleep_ticks;
    assign rd_idx_inc = rd_idx_reg + CNT_W'(1);
    assign last_entry = (rd_idx_inc == count_reg);

    // shared countdown unit
    tsq_entry_eval u_eval (
        .ticks (rd_data_reg.ticks),
        .res   (ev)
    );

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_TICK) && (count_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_entry)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath control and result generation
    always_comb
    begin
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        keep_next       = keep_reg;
        pend_valid_next = pend_valid_reg;
        pend_task_next  = pend_task_reg;
        out_valid_next  = 1'b0;
        out_wake_next   = 1'b0;
        out_task_next   = '0;
        out_status_next = STATUS_OK;
        out_last_next   = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = count_reg[IDX_W-1:0];
        wr_data.task_id = task_id;
        wr_data.ticks   = ticks_adj;
        rd_addr         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == REQ_SLEEP)
                    begin
                        // append at tail unless zero ticks or full
                        if ((sleep_ticks != '0) && !sleep_full)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        out_valid_next  = 1'b1;
                        out_status_next = ((sleep_ticks != '0) && sleep_full) ? STATUS_FULL
                                                                               : STATUS_OK;
                        out_last_next   = 1'b1;
                    end
                    else
                    begin
                        // start the walk at entry zero
                        rd_idx_next     = '0;
                        keep_next       = '0;
                        pend_valid_next = 1'b0;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_addr     = rd_idx_inc[IDX_W-1:0];
                rd_idx_next = rd_idx_inc;
                if (ev.wake)
                begin
                    // a later wake means the held report is not the last one
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_wake_next  = 1'b1;
                        out_task_next  = pend_task_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_task_next  = rd_data_reg.task_id;
                end
                else
                begin
                    // compact surviving entry toward the head
                    wr_en           = 1'b1;
                    wr_addr         = keep_reg[IDX_W-1:0];
                    wr_data.task_id = rd_data_reg.task_id;
                    wr_data.ticks   = ev.ticks;
                    keep_next       = keep_reg + CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                count_next = keep_reg;
                if (pend_valid_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_wake_next   = 1'b1;
                    out_task_next   = pend_task_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            keep_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            keep_reg       <= keep_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_task_reg  <= pend_task_next;
        out_wake_reg   <= out_wake_next;
        out_task_reg   <= out_task_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = out_valid_reg;
    assign is_wake       = out_wake_reg;
    assign woken_task    = out_task_reg;
    assign status        = out_status_reg;
    assign last          = out_last_reg;

    // checks
    `TSQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_CNT)
    `TSQ_ASSERT_IMPL(a_keep_behind, clk, rst_n, state_reg == ST_SCAN, keep_reg <= rd_idx_reg)
    `TSQ_ASSERT_NEXT(a_sleep_status, clk, rst_n, accept && (req_type == REQ_SLEEP),
                     result_strobe && !is_wake && last)
    `TSQ_ASSERT_NEXT(a_finish_idle, clk, rst_n, state_reg == ST_FINISH,
                     state_reg == ST_IDLE && !pend_valid_reg)

endmodule

`default_nettype wire

@@ tb/tb_task_sleep_timer_queue_core.sv @@
// self-checking testbench for the sleep timer queue core
`default_nettype none

module tb_task_sleep_timer_queue_core;

    localparam int DEPTH = 16;
    localparam int RANDOM_REQUESTS = 125;
    localparam int SETTLE_CYCLES = DEPTH + 8;
    localparam int TIMEOUT_CYCLES = 200000;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        req_type;
    logic [tsq_pkg::TASK_W-1:0]  task_id;
    logic [tsq_pkg::TICK_W-1:0]  sleep_ticks;
    logic                        result_strobe;
    logic                        is_wake;
    logic [tsq_pkg::TASK_W-1:0]  woken_task;
    logic                        status;
    logic                        last;

    // one result row as the block shows it
    typedef struct {
        logic                       is_wake;
        logic [tsq_pkg::TASK_W-1:0] woken_task;
        logic                       status;
        logic                       last;
    } result_t;

    // tracks the sleep queue and the results each request should give
    class wake_scoreboard;
        logic [tsq_pkg::TASK_W-1:0] sleeper_id[$];
        logic [tsq_pkg::TICK_W-1:0] sleeper_ticks[$];
        result_t                    expected_results[$];
        int                         mismatches;
        int                         sleeps;
        int                         ticks;
        int                         wakes;
        int                         full_drops;
        int                         checked;

        function new();
            mismatches = 0;
            sleeps = 0;
            ticks = 0;
            wakes = 0;
            full_drops = 0;
            checked = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
            mismatches++;
        endtask

        // note an accepted request and queue the results it causes
        function void note_request(logic req, logic [tsq_pkg::TASK_W-1:0] id,
                                   logic [tsq_pkg::TICK_W-1:0] count);
            result_t                    r;
            logic [tsq_pkg::TASK_W-1:0] keep_id[$];
            logic [tsq_pkg::TICK_W-1:0] keep_ticks[$];
            logic [tsq_pkg::TICK_W-1:0] t;
            int                         first_wake;

            if (req == tsq_pkg::REQ_SLEEP) begin
                sleeps++;
                r.is_wake = 1'b0;
                r.woken_task = '0;
                r.status = tsq_pkg::STATUS_OK;
                r.last = 1'b1;
                if (count != '0) begin
                    // the off value is stored one below
                    if (count == tsq_pkg::TIMEROFF16)
                        count = count - 1'b1;
                    if (sleeper_id.size() < DEPTH) begin
                        sleeper_id.push_back(id);
                        sleeper_ticks.push_back(count);
                    end
                    else begin
                        r.status = tsq_pkg::STATUS_FULL;
                        full_drops++;
                    end
                end
                expected_results.push_back(r);
                return;
            end

            // tick: count down every entry, wake the expired ones in queue order
            ticks++;
            first_wake = expected_results.size();
            foreach (sleeper_id[i]) begin
                t = sleeper_ticks[i];
                if (t != tsq_pkg::TIMEROFF16)
                    t = t - 1'b1;
                if (t == '0 || sleeper_ticks[i] == tsq_pkg::TIMEROFF16) begin
                    r.is_wake = 1'b1;
                    r.woken_task = sleeper_id[i];
                    r.status = tsq_pkg::STATUS_OK;
                    r.last = 1'b0;
                    expected_results.push_back(r);
                    wakes++;
                end
                else begin
                    keep_id.push_back(sleeper_id[i]);
                    keep_ticks.push_back(t);
                end
            end
            sleeper_id = keep_id;
            sleeper_ticks = keep_ticks;
            if (expected_results.size() > first_wake)
                expected_results[expected_results.size()-1].last = 1'b1;
        endfunction

        // compare one strobed result with the oldest expectation
        task check_result(logic wake, logic [tsq_pkg::TASK_W-1:0] id,
                          logic st, logic lst);
            result_t e;

            checked++;
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", {wake, id, st, lst}, '0);
                return;
            end
            e = expected_results.pop_front();
            if (wake !== e.is_wake)
                report_mismatch("is_wake", wake, e.is_wake);
            if (id !== e.woken_task)
                report_mismatch("woken_task", id, e.woken_task);
            if (st !== e.status)
                report_mismatch("status", st, e.status);
            if (lst !== e.last)
                report_mismatch("last", lst, e.last);
        endtask
    endclass

    wake_scoreboard board;

    task_sleep_timer_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .task_id(task_id),
        .sleep_ticks(sleep_ticks),
        .result_strobe(result_strobe),
        .is_wake(is_wake),
        .woken_task(woken_task),
        .status(status),
        .last(last)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result monitor, samples at the edge that ends the strobe cycle
    always @(posedge clk)
    begin
        if (rst_n && result_strobe === 1'b1)
            board.check_result(is_wake, woken_task, status, last);
    end

    // run limit
    initial
    begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("timeout with %0d results still expected", board.pending());
        $display("tb_task_sleep_timer_queue_core: FAIL");
        $finish;
    end

    // present one request and hold it until the block takes it
    task automatic send_request(input logic req, input logic [tsq_pkg::TASK_W-1:0] id,
                                input logic [tsq_pkg::TICK_W-1:0] count);
        start <= 1'b1;
        req_type <= req;
        task_id <= id;
        sleep_ticks <= count;
        do @(posedge clk); while (busy !== 1'b0);
        board.note_request(req, id, count);
    endtask

    // drop start for a number of cycles with noise on the fields
    task automatic idle_for(input int cycles);
        start <= 1'b0;
        req_type <= $urandom_range(0, 1);
        task_id <= $urandom_range(0, 255);
        sleep_ticks <= $urandom_range(0, 65535);
        repeat (cycles) @(posedge clk);
    endtask

    // hold the sender until every expected result has been seen
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (board.pending() > 0);
    endtask

    // stimulus
    initial
    begin
        int gap;
        int pick;
        logic [tsq_pkg::TICK_W-1:0] count;

        board = new();
        rst_n = 1'b0;
        start = 1'b0;
        req_type = tsq_pkg::REQ_TICK;
        task_id = '0;
        sleep_ticks = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, zero ticks, field extremes, off value
        send_request(tsq_pkg::REQ_TICK, 8'h00, 16'h0000);
        send_request(tsq_pkg::REQ_SLEEP, 8'h3c, 16'h0000);
        send_request(tsq_pkg::REQ_SLEEP, 8'h00, 16'h0001);
        send_request(tsq_pkg::REQ_SLEEP, 8'hff, 16'h0002);
        send_request(tsq_pkg::REQ_SLEEP, 8'ha5, tsq_pkg::TIMEROFF16);
        send_request(tsq_pkg::REQ_TICK, 8'hff, 16'hffff);
        send_request(tsq_pkg::REQ_TICK, 8'h00, 16'h0000);
        // fill the queue, then hit it when full
        for (int i = 0; i < DEPTH - 1; i++)
            send_request(tsq_pkg::REQ_SLEEP, 8'(i * 17 + 1), 16'(i % 3 + 1));
        send_request(tsq_pkg::REQ_SLEEP, 8'h5a, 16'h0007);
        send_request(tsq_pkg::REQ_SLEEP, 8'h5c, 16'h0003);
        send_request(tsq_pkg::REQ_SLEEP, 8'h5b, 16'h0000);
        // ticks that wake several entries at once
        drain_results();
        send_request(tsq_pkg::REQ_TICK, 8'h00, 16'h0000);
        send_request(tsq_pkg::REQ_TICK, 8'h00, 16'h0000);
        send_request(tsq_pkg::REQ_TICK, 8'h00, 16'h0000);

        // random part
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                count = '0;
            else if (pick < 88)
                count = 16'($urandom_range(1, 6));
            else if (pick < 98)
                count = 16'($urandom_range(7, 40));
            else
                count = 16'($urandom_range(1, 65535));
            if ($urandom_range(0, 99) < 55)
                send_request(tsq_pkg::REQ_SLEEP, 8'($urandom_range(0, 255)), count);
            else
                send_request(tsq_pkg::REQ_TICK, 8'($urandom_range(0, 255)), count);

            // bursts with no gaps, otherwise mostly short gaps and a few long ones
            if (n == RANDOM_REQUESTS / 2) begin
                drain_results();
            end
            else if ((n / 20) % 3 != 1) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    gap = 0;
                else if (pick < 85)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(5, 30);
                if (gap > 0)
                    idle_for(gap);
            end
        end

        // let everything come out, then allow for a trailing walk
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("ran %0d sleep and %0d tick requests: %0d wake reports, %0d full drops",
                 board.sleeps, board.ticks, board.wakes, board.full_drops);
        $display("checked %0d results, %0d mismatches, %0d left expected",
                 board.checked, board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb_task_sleep_timer_queue_core: PASS");
        else
            $display("tb_task_sleep_timer_queue_core: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/tsq_pkg.sv
rtl/tsq_entry_eval.sv
rtl/task_sleep_timer_queue_core.sv
tb/tb_task_sleep_timer_queue_core.sv
